// ===== rtl/atwa_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// atwa_pkg
// Shared widths, operation codes and mode codes for the time-weighted
// activity averager.
// ---------------------------------------------------------------------------
package atwa_pkg;

  // field widths
  localparam int OP_W    = 2;
  localparam int MODE_W  = 2;
  localparam int STAMP_W = 32;
  localparam int TOT_W   = 32;
  localparam int SMP_W   = 16;
  localparam int DT_W    = 15;   // step after clamping negatives to zero
  localparam int STRK_W  = 8;
  localparam int PROD_W  = SMP_W + DT_W;
  localparam int SUM_W   = 48;
  localparam int AVG_W   = 16;
  localparam int NUM_CH  = 3;    // speed, cadence, power
  localparam int IDX_W   = 2;

  // stream widths (whole bytes)
  localparam int IN_TDATA_W  = 152;
  localparam int OUT_TDATA_W = 248;

  // averages are recomputed only for sessions longer than this
  localparam logic [TOT_W-1:0] MIN_TIME_MS = 32'd1;

  // operation codes
  localparam logic [OP_W-1:0] OP_START  = 2'd0;
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP   = 2'd2;

  // session modes
  localparam logic [MODE_W-1:0] MODE_IDLE    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RECORD  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STOPPED = 2'd2;

  // status codes
  localparam logic ST_OK     = 1'b0;
  localparam logic ST_REJECT = 1'b1;

endpackage : atwa_pkg
`default_nettype wire

// ===== rtl/atwa_div_unit.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// atwa_div_unit
// Restoring divider, one quotient bit a cycle: 48-bit sum over a 32-bit
// duration, quotient saturated to 16 bits. Overflow is found up front by
// comparing the upper 32 bits of the sum with the divisor.
// ---------------------------------------------------------------------------
module atwa_div_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [atwa_pkg::SUM_W-1:0]    dividend,
  input  wire logic [atwa_pkg::TOT_W-1:0]    divisor,
  output logic                               done,
  output logic [atwa_pkg::AVG_W-1:0]         quotient
);
  import atwa_pkg::*;

  localparam int CNT_W = $clog2(AVG_W + 1);
  localparam logic [CNT_W-1:0] STEPS = CNT_W'(AVG_W);

  logic                 busy_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [TOT_W-1:0]     rem_r;
  logic [AVG_W-1:0]     q_r;
  logic [TOT_W:0]       rem_sh;
  logic [TOT_W:0]       rem_sub;
  logic                 ge;

  // one restoring step
  assign rem_sh  = {rem_r, q_r[AVG_W-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign ge      = rem_sh >= {1'b0, divisor};

  assign done     = busy_r && (cnt_r == '0);
  assign quotient = q_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= (dividend[SUM_W-1:AVG_W] >= divisor) ? '0 : STEPS;
    end else if (done) begin
      busy_r <= 1'b0;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      if (dividend[SUM_W-1:AVG_W] >= divisor) begin
        q_r   <= '1;
        rem_r <= '0;
      end else begin
        q_r   <= dividend[AVG_W-1:0];
        rem_r <= dividend[SUM_W-1:AVG_W];
      end
    end else if (busy_r && (cnt_r != '0)) begin
      rem_r <= ge ? rem_sub[TOT_W-1:0] : rem_sh[TOT_W-1:0];
      q_r   <= {q_r[AVG_W-2:0], ge};
    end
  end

endmodule : atwa_div_unit
`default_nettype wire

// ===== rtl/activity_time_weighted_averager_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// activity_time_weighted_averager_core
// Session recorder: start / update / stop, saturating totals, dt-weighted
// sums of speed, cadence and power, averages by a shared divider, peaks.
// ---------------------------------------------------------------------------
//  channel | direction | tdata                         | tuser
//  in_     | slave     | times, step, samples (152 b)  | operation (2 b)
//  out_    | master    | mode, totals, means... (248 b)| status (1 b)
//
//  Start, stop and rejected items go from accept straight to the result
//  register. An update makes three multiply/accumulate passes on the one
//  16x15 multiplier, then three 16-step divisions on the shared divider
//  (cut short when the quotient saturates); with 1 ms or less recorded the
//  divisions are skipped. in_tready is low while an item is being worked on.
//  Synchronous active-low reset returns to idle; a finished result waits
//  while out_tready is low.
// ---------------------------------------------------------------------------
module activity_time_weighted_averager_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // in_tdata: requested_time, now_time, step_ms, speed_mmps, cadence_centi,
  //           power_dw, distance_step_mm, stroke_step
  input  wire logic [atwa_pkg::IN_TDATA_W-1:0]     in_tdata,
  // in_tuser: operation
  input  wire logic [atwa_pkg::OP_W-1:0]           in_tuser,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // out_tdata: mode, distance_mm, strokes, elapsed_ms, mean_speed,
  //            mean_cadence, mean_power, peak_speed, peak_cadence,
  //            session_start, session_end, zero pad
  output logic [atwa_pkg::OUT_TDATA_W-1:0]         out_tdata,
  // out_tuser: status
  output logic                                     out_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready
);
  import atwa_pkg::*;

  // sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_DIVG = 3'd3;
  localparam logic [2:0] S_DIVW = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam logic [IDX_W-1:0] LAST_CH = IDX_W'(NUM_CH - 1);

  function automatic logic [TOT_W-1:0] sat_add32(input logic [TOT_W-1:0] a,
                                                 input logic [TOT_W-1:0] b);
    logic [TOT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TOT_W] ? '1 : s[TOT_W-1:0];
  endfunction

  // input fields
  logic [OP_W-1:0]    in_op;
  logic [STAMP_W-1:0] in_req, in_now, in_stamp;
  logic [SMP_W-1:0]   in_step, in_spd, in_cad, in_pwr, in_dist;
  logic [STRK_W-1:0]  in_strk;
  logic               in_acc;

  assign in_op   = in_tuser;
  assign in_req  = in_tdata[31:0];
  assign in_now  = in_tdata[63:32];
  assign in_step = in_tdata[79:64];
  assign in_spd  = in_tdata[95:80];
  assign in_cad  = in_tdata[111:96];
  assign in_pwr  = in_tdata[127:112];
  assign in_dist = in_tdata[143:128];
  assign in_strk = in_tdata[151:144];
  assign in_stamp = (in_req != '0) ? in_req : in_now;

  // state
  logic [2:0]         state_r;
  logic [IDX_W-1:0]   idx_r;
  logic [MODE_W-1:0]  mode_r;
  logic               status_r;
  logic [STAMP_W-1:0] start_r, end_r;
  logic [TOT_W-1:0]   dist_r, strk_r, time_r;
  logic [SUM_W-1:0]   sums_r [NUM_CH];
  logic [AVG_W-1:0]   avgs_r [NUM_CH];
  logic [SMP_W-1:0]   peak_spd_r, peak_cad_r;
  logic [DT_W-1:0]    dt_r;
  logic [SMP_W-1:0]   vals_r [NUM_CH];
  logic [PROD_W-1:0]  prod_r;
  logic               out_valid_r;
  logic               out_status_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // shared datapath pieces
  logic [SMP_W-1:0] mul_a;
  logic [SUM_W:0]   acc_sum;
  logic             div_start, div_done;
  logic [AVG_W-1:0] div_q;
  logic             load_out;

  assign mul_a    = vals_r[idx_r];
  assign acc_sum  = {1'b0, sums_r[idx_r]} + {{(SUM_W+1-PROD_W){1'b0}}, prod_r};
  assign div_start = (state_r == S_DIVG);
  assign load_out  = (state_r == S_DONE) && (!out_valid_r || out_tready);

  atwa_div_unit u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sums_r[idx_r]),
    .divisor  (time_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // sequencer and session state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      idx_r      <= '0;
      mode_r     <= MODE_IDLE;
      status_r   <= ST_OK;
      start_r    <= '0;
      end_r      <= '0;
      dist_r     <= '0;
      strk_r     <= '0;
      time_r     <= '0;
      peak_spd_r <= '0;
      peak_cad_r <= '0;
      for (int i = 0; i < NUM_CH; i++) begin
        sums_r[i] <= '0;
        avgs_r[i] <= '0;
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            idx_r <= '0;
            if (in_op == OP_START) begin
              status_r   <= ST_OK;
              state_r    <= S_DONE;
              mode_r     <= MODE_RECORD;
              start_r    <= in_stamp;
              end_r      <= '0;
              dist_r     <= '0;
              strk_r     <= '0;
              time_r     <= '0;
              peak_spd_r <= '0;
              peak_cad_r <= '0;
              for (int i = 0; i < NUM_CH; i++) begin
                sums_r[i] <= '0;
                avgs_r[i] <= '0;
              end
            end else if (in_op == OP_UPDATE && mode_r == MODE_RECORD) begin
              status_r <= ST_OK;
              dist_r   <= sat_add32(dist_r, {{(TOT_W-SMP_W){1'b0}}, in_dist});
              strk_r   <= sat_add32(strk_r, {{(TOT_W-STRK_W){1'b0}}, in_strk});
              time_r   <= sat_add32(time_r, in_step[SMP_W-1] ? '0 :
                                    {{(TOT_W-SMP_W){1'b0}}, in_step});
              if (in_spd > peak_spd_r) peak_spd_r <= in_spd;
              if (in_cad > peak_cad_r) peak_cad_r <= in_cad;
              state_r <= S_MUL;
            end else if (in_op == OP_STOP && mode_r == MODE_RECORD) begin
              status_r <= ST_OK;
              state_r  <= S_DONE;
              mode_r   <= MODE_STOPPED;
              end_r    <= in_stamp;
            end else begin
              // wrong mode or unknown operation
              status_r <= ST_REJECT;
              state_r  <= S_DONE;
            end
          end
        end
        S_MUL: begin
          state_r <= S_ACC;
        end
        S_ACC: begin
          sums_r[idx_r] <= acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];
          if (idx_r == LAST_CH) begin
            idx_r   <= '0;
            state_r <= (time_r > MIN_TIME_MS) ? S_DIVG : S_DONE;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_MUL;
          end
        end
        S_DIVG: begin
          state_r <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            avgs_r[idx_r] <= div_q;
            if (idx_r == LAST_CH) begin
              idx_r   <= '0;
              state_r <= S_DONE;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_DIVG;
            end
          end
        end
        S_DONE: begin
          if (load_out) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // sample capture and the shared multiplier
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dt_r      <= in_step[SMP_W-1] ? '0 : in_step[DT_W-1:0];
      vals_r[0] <= in_spd;
      vals_r[1] <= in_cad;
      vals_r[2] <= in_pwr;
    end
    if (state_r == S_MUL) begin
      prod_r <= {{(PROD_W-SMP_W){1'b0}}, mul_a} * {{(PROD_W-DT_W){1'b0}}, dt_r};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= status_r;
      out_data_r   <= {{(OUT_TDATA_W-242){1'b0}}, end_r, start_r, peak_cad_r,
                       peak_spd_r, avgs_r[2], avgs_r[1], avgs_r[0], time_r,
                       strk_r, dist_r, mode_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule : activity_time_weighted_averager_core
`default_nettype wire

// ===== tb/sv/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Self-checking testbench for activity_time_weighted_averager_core. Items
// go in on the in_ stream and session reports are checked on the out_
// stream against a cycle-free predictor of the session recorder. Directed
// tests cover the mode rules, the timestamp choice, step clamping, short
// sessions and field extremes. Random sessions follow, with start/update/
// stop sequences mixed with rejected and unknown operations. Both stream
// sides stall at random.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import atwa_pkg::*;

  localparam logic [OP_W-1:0] OP_UNKNOWN  = 2'd3;
  localparam int              ITEM_TARGET = 826;
  localparam logic [SUM_W-1:0] SUM_CEIL   = {SUM_W{1'b1}};
  localparam logic [TOT_W-1:0] TOT_CEIL   = {TOT_W{1'b1}};

  // one input item
  typedef struct {
    logic [OP_W-1:0]    op;
    logic [31:0]        req_time;
    logic [31:0]        now_time;
    logic signed [15:0] step_ms;
    logic [15:0]        speed;
    logic [15:0]        cadence;
    logic [15:0]        power;
    logic [15:0]        dist_step;
    logic [7:0]         stroke_step;
  } sample_t;

  // one session report
  typedef struct {
    logic              status;
    logic [MODE_W-1:0] mode;
    logic [31:0]       distance;
    logic [31:0]       strokes;
    logic [31:0]       duration;
    logic [15:0]       mean_speed;
    logic [15:0]       mean_cadence;
    logic [15:0]       mean_power;
    logic [15:0]       peak_speed;
    logic [15:0]       peak_cadence;
    logic [31:0]       start_stamp;
    logic [31:0]       end_stamp;
  } report_t;

  logic                   clk;
  logic                   rst_n;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [OP_W-1:0]        in_tuser;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tvalid;
  logic                   out_tready;

  // predicted session state
  logic [MODE_W-1:0] sess_mode;
  logic [31:0]       sess_start;
  logic [31:0]       sess_end;
  logic [31:0]       sess_distance;
  logic [31:0]       sess_strokes;
  logic [31:0]       sess_duration;
  logic [63:0]       sess_wsum [NUM_CH];
  logic [15:0]       sess_mean [NUM_CH];
  logic [15:0]       sess_peak_speed;
  logic [15:0]       sess_peak_cadence;

  report_t pending_reports[$];
  int      mismatches;
  bit      no_idle;

  activity_time_weighted_averager_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // session state cleared by a start item
  function automatic void clear_session();
    sess_end          = '0;
    sess_distance     = '0;
    sess_strokes      = '0;
    sess_duration     = '0;
    sess_peak_speed   = '0;
    sess_peak_cadence = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      sess_wsum[i] = '0;
      sess_mean[i] = '0;
    end
  endfunction

  function automatic logic [31:0] add_sat32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? TOT_CEIL : s[31:0];
  endfunction

  // apply one item to the predicted state and return the expected report
  function automatic report_t advance_session(input sample_t s);
    report_t    r;
    logic [31:0] dt;
    logic [63:0] vals [NUM_CH];
    logic [63:0] q;
    r.status = ST_REJECT;
    if (s.op == OP_START) begin
      clear_session();
      sess_start = (s.req_time != 0) ? s.req_time : s.now_time;
      sess_mode  = MODE_RECORD;
      r.status   = ST_OK;
    end else if (s.op == OP_UPDATE && sess_mode == MODE_RECORD) begin
      // negative steps count as no time
      dt = s.step_ms[15] ? 32'd0 : {17'd0, s.step_ms[14:0]};
      vals[0] = {48'd0, s.speed};
      vals[1] = {48'd0, s.cadence};
      vals[2] = {48'd0, s.power};
      sess_distance = add_sat32(sess_distance, {16'd0, s.dist_step});
      sess_strokes  = add_sat32(sess_strokes, {24'd0, s.stroke_step});
      sess_duration = add_sat32(sess_duration, dt);
      for (int i = 0; i < NUM_CH; i++) begin
        sess_wsum[i] = sess_wsum[i] + vals[i] * {32'd0, dt};
        if (sess_wsum[i] > {16'd0, SUM_CEIL}) sess_wsum[i] = {16'd0, SUM_CEIL};
      end
      // averages only once the session is longer than the minimum
      if (sess_duration > MIN_TIME_MS) begin
        for (int i = 0; i < NUM_CH; i++) begin
          q = sess_wsum[i] / {32'd0, sess_duration};
          sess_mean[i] = (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
        end
      end
      if (s.speed > sess_peak_speed)     sess_peak_speed   = s.speed;
      if (s.cadence > sess_peak_cadence) sess_peak_cadence = s.cadence;
      r.status = ST_OK;
    end else if (s.op == OP_STOP && sess_mode == MODE_RECORD) begin
      sess_end  = (s.req_time != 0) ? s.req_time : s.now_time;
      sess_mode = MODE_STOPPED;
      r.status  = ST_OK;
    end
    r.mode         = sess_mode;
    r.distance     = sess_distance;
    r.strokes      = sess_strokes;
    r.duration     = sess_duration;
    r.mean_speed   = sess_mean[0];
    r.mean_cadence = sess_mean[1];
    r.mean_power   = sess_mean[2];
    r.peak_speed   = sess_peak_speed;
    r.peak_cadence = sess_peak_cadence;
    r.start_stamp  = sess_start;
    r.end_stamp    = sess_end;
    return r;
  endfunction

  // drive one item, wait for the handshake, record the expected report
  task automatic send_item(input sample_t s, output logic status);
    int      gap;
    report_t r;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = {s.stroke_step, s.dist_step, s.power, s.cadence, s.speed,
                 s.step_ms, s.now_time, s.req_time};
    in_tuser  = s.op;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    r = advance_session(s);
    pending_reports.push_back(r);
    status = r.status;
    @(negedge clk);
  endtask

  function automatic sample_t make_item(input logic [OP_W-1:0] op);
    sample_t s;
    s.op          = op;
    s.req_time    = $urandom;
    s.now_time    = $urandom;
    s.step_ms     = 16'($urandom_range(2, 1500));
    s.speed       = 16'($urandom);
    s.cadence     = 16'($urandom);
    s.power       = 16'($urandom);
    s.dist_step   = 16'($urandom);
    s.stroke_step = 8'($urandom);
    return s;
  endfunction

  task automatic send_op(input logic [OP_W-1:0] op);
    logic st;
    send_item(make_item(op), st);
  endtask

  task automatic send_update(input logic [15:0] step, input logic [15:0] level);
    sample_t s;
    logic    st;
    s = make_item(OP_UPDATE);
    s.step_ms = step;
    s.speed   = level;
    s.cadence = level;
    s.power   = level;
    send_item(s, st);
  endtask

  task automatic send_stamped(input logic [OP_W-1:0] op, input logic [31:0] req,
                              input logic [31:0] now);
    sample_t s;
    logic    st;
    s = make_item(op);
    s.req_time = req;
    s.now_time = now;
    send_item(s, st);
  endtask

  // everything outside a session is rejected, state stays at reset values
  task automatic test_idle_rejects();
    send_op(OP_UPDATE);
    send_op(OP_STOP);
    send_op(OP_UNKNOWN);
  endtask

  // start stamp from the request, or from the current time when zero
  task automatic test_start_stamps();
    send_stamped(OP_START, 32'd0, 32'hFFFF_FFFF);
    send_stamped(OP_START, 32'hFFFF_FFFF, 32'd0);
    send_stamped(OP_START, 32'd1, 32'hFFFF_FFFF);
  endtask

  // steps: short session, negative, zero and widest, field extremes
  task automatic test_update_extremes();
    sample_t s;
    logic    st;
    send_update(16'd1, 16'hFFFF);
    send_update(16'h8000, 16'hFFFF);
    send_update(16'hFFFF, 16'd0);
    send_update(16'd0, 16'hFFFF);
    send_update(16'd1, 16'd0);
    send_update(16'h7FFF, 16'hFFFF);
    send_update(16'd2, 16'd0);
    s = make_item(OP_UPDATE);
    s.dist_step   = 16'hFFFF;
    s.stroke_step = 8'hFF;
    s.step_ms     = 16'h7FFF;
    send_item(s, st);
    s.dist_step   = 16'd0;
    s.stroke_step = 8'd0;
    s.step_ms     = 16'd0;
    send_item(s, st);
  endtask

  // stop, then every operation is rejected until the next start
  task automatic test_stop_and_restart();
    send_stamped(OP_STOP, 32'd0, 32'hFFFF_FFFF);
    send_op(OP_UPDATE);
    send_op(OP_STOP);
    send_op(OP_UNKNOWN);
    send_stamped(OP_START, 32'd0, 32'd0);
    send_update(16'd500, 16'd1000);
    send_op(OP_START);
    send_op(OP_UNKNOWN);
    send_stamped(OP_STOP, 32'hFFFF_FFFF, 32'd0);
  endtask

  // random sessions with noise and broken sequences mixed in
  task automatic test_random_sessions();
    int         n_sent;
    int         pick;
    int         sel;
    sample_t    s;
    logic       st;
    logic [OP_W-1:0] op;
    n_sent = 0;
    while (n_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (sess_mode == MODE_RECORD)
        op = (pick < 85) ? OP_UPDATE : (pick < 91) ? OP_STOP :
             (pick < 95) ? OP_START : OP_UNKNOWN;
      else
        op = (pick < 70) ? OP_START : (pick < 80) ? OP_UPDATE :
             (pick < 90) ? OP_STOP : OP_UNKNOWN;
      if (op == OP_START) no_idle = ($urandom_range(0, 3) == 0);
      s = make_item(op);
      if ($urandom_range(0, 3) == 0) s.req_time = '0;
      sel = $urandom_range(0, 19);
      case (sel)
        0: begin
          s.step_ms = 16'h8000 | 16'($urandom);
        end
        1: begin
          s.step_ms = 16'd0;
        end
        2: begin
          s.step_ms = 16'd1;
        end
        3: begin
          s.step_ms = 16'($urandom_range(0, 32767));
        end
        default: ;
      endcase
      send_item(s, st);
      n_sent++;
    end
    no_idle = 1'b0;
  endtask

  // field compare; first few mismatches reported in full
  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h, got %h at %0t", name, want, got, $realtime);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item at %0t", $realtime);
      end else begin
        want = pending_reports.pop_front();
        compare_field("status", 32'(want.status), 32'(out_tuser));
        compare_field("mode", 32'(want.mode), 32'(out_tdata[1:0]));
        compare_field("distance_mm", want.distance, out_tdata[33:2]);
        compare_field("strokes", want.strokes, out_tdata[65:34]);
        compare_field("elapsed_ms", want.duration, out_tdata[97:66]);
        compare_field("mean_speed", 32'(want.mean_speed), 32'(out_tdata[113:98]));
        compare_field("mean_cadence", 32'(want.mean_cadence),
                      32'(out_tdata[129:114]));
        compare_field("mean_power", 32'(want.mean_power), 32'(out_tdata[145:130]));
        compare_field("peak_speed", 32'(want.peak_speed), 32'(out_tdata[161:146]));
        compare_field("peak_cadence", 32'(want.peak_cadence),
                      32'(out_tdata[177:162]));
        compare_field("session_start", want.start_stamp, out_tdata[209:178]);
        compare_field("session_end", want.end_stamp, out_tdata[241:210]);
      end
    end
  end

  // result side back-pressure
  initial begin
    int gap;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        out_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      @(negedge clk);
    end
  end

  // run limit
  initial begin
    #8_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // main sequence
  initial begin
    mismatches = 0;
    no_idle    = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    sess_mode  = MODE_IDLE;
    sess_start = '0;
    clear_session();
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_idle_rejects();
    test_start_stamps();
    test_update_extremes();
    test_stop_and_restart();
    test_random_sessions();
    in_tvalid = 1'b0;
    wait (pending_reports.size() == 0);
    repeat (80) @(posedge clk);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
